// File: rtl/irpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants for the IR pulse-distance frame sender.
// ----------------------------------------------------------------------------
package irpd_pkg;

    // Command codes carried by an input item
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    // Frame layout
    localparam int FRAME_BITS = 32;
    localparam logic [5:0] FRAME_BITS_INIT = 6'd32;
    localparam int SLOT_W = 4;

    typedef struct packed {
        logic       command;
        logic [7:0] address;
        logic [7:0] key_code;
    } irpd_item_t;

    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic frame_done;
    } irpd_result_t;

    // Handshake between the input register and the engine
    typedef struct packed {
        logic valid;
        logic take;
    } irpd_stage_hs_t;

endpackage

// File: rtl/irpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_if
// Valid/ready channels for the send/tick items and the slot results.
// ----------------------------------------------------------------------------
interface irpd_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] address;
    logic [7:0] key_code;

    modport source (output valid, output command, output address, output key_code,
                    input ready);
    modport sink   (input valid, input command, input address, input key_code,
                    output ready);
endinterface

interface irpd_result_if;
    logic valid;
    logic ready;
    logic ir_level;
    logic busy_res;
    logic frame_done;

    modport source (output valid, output ir_level, output busy_res, output frame_done,
                    input ready);
    modport sink   (input valid, input ir_level, input busy_res, input frame_done,
                    output ready);
endinterface

// File: rtl/ir_pulse_distance_frame_sender.sv
`timescale 1ns / 1ps
// Path: an accepted item waits in the input register, then its result in the result register.
// Throughput: one item per cycle while the sink takes results; the input register and
// the result register let a new item enter while a finished result waits for the sink.
// Reset (rst_n low, asynchronous): frame idle, both registers empty.
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_sender
// IR frame sender: lead mark/space, 32 pulse-distance data bits, stop mark.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_sender #(
    parameter int LEAD_MARK_SLOTS  = 8,
    parameter int LEAD_SPACE_SLOTS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    irpd_item_if.sink            items,
    irpd_result_if.source        results
);
    import irpd_pkg::*;

    irpd_item_t     in_item;
    irpd_item_t     held_item;
    irpd_stage_hs_t hs;
    irpd_result_t   result;
    logic           take;

    assign in_item.command  = items.command;
    assign in_item.address  = items.address;
    assign in_item.key_code = items.key_code;

    // Input register
    irpd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .in_item  (in_item),
        .take     (take),
        .hs       (hs),
        .item     (held_item)
    );

    // Frame sequencer and result register
    irpd_engine #(
        .LEAD_MARK_SLOTS  (LEAD_MARK_SLOTS),
        .LEAD_SPACE_SLOTS (LEAD_SPACE_SLOTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .hs        (hs),
        .item      (held_item),
        .take      (take),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .result    (result)
    );

    assign results.ir_level   = result.ir_level;
    assign results.busy_res   = result.busy_res;
    assign results.frame_done = result.frame_done;

endmodule

// File: rtl/irpd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_in_stage
// Input register: captures one item per cycle, while the engine takes the held item, ahead of the frame engine.
// ----------------------------------------------------------------------------
module irpd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  irpd_pkg::irpd_item_t in_item,
    input  logic                take,
    output irpd_pkg::irpd_stage_hs_t hs,
    output irpd_pkg::irpd_item_t item
);
    import irpd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    irpd_item_t item_reg;

    // Free when empty or when the engine takes the held item this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign hs.valid = valid_reg;
    assign hs.take  = take;
    assign item     = item_reg;

endmodule

// File: rtl/irpd_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_engine
// Frame sequencer: one slot decision per item, result held in an output register.
// ----------------------------------------------------------------------------
module irpd_engine #(
    parameter int LEAD_MARK_SLOTS  = 8,
    parameter int LEAD_SPACE_SLOTS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  irpd_pkg::irpd_stage_hs_t hs,
    input  irpd_pkg::irpd_item_t     item,
    output logic                     take,
    output logic                     out_valid,
    input  logic                     out_ready,
    output irpd_pkg::irpd_result_t   result
);
    import irpd_pkg::*;

    typedef enum logic [2:0] {
        SEG_IDLE,
        SEG_LEAD_MARK,
        SEG_LEAD_SPACE,
        SEG_DATA,
        SEG_STOP,
        SEG_END
    } seg_t;

    localparam logic [SLOT_W-1:0] MARK_INIT  = SLOT_W'(LEAD_MARK_SLOTS);
    localparam logic [SLOT_W-1:0] SPACE_INIT = SLOT_W'(LEAD_SPACE_SLOTS);

    logic                  active_reg, active_next;
    seg_t                  seg_reg, seg_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [FRAME_BITS-1:0] bits_reg, bits_next;
    logic [5:0]            left_reg, left_next;
    logic [1:0]            phase_reg, phase_next;
    logic                  out_valid_reg, out_valid_next;
    irpd_result_t          result_reg, result_next;

    logic                  process;
    logic [1:0]            last_phase;
    logic [5:0]            left_dec;

    // Output register frees up when empty or when the sink takes it
    assign take    = hs.valid && (!out_valid_reg || out_ready);
    assign process = take;

    assign last_phase = bits_reg[FRAME_BITS-1] ? 2'd3 : 2'd1;
    assign left_dec   = left_reg - 6'd1;

    // Slot decision and state advance
    always_comb
    begin
        active_next = active_reg;
        seg_next    = seg_reg;
        slot_next   = slot_reg;
        bits_next   = bits_reg;
        left_next   = left_reg;
        phase_next  = phase_reg;
        result_next = result_reg;

        if (process)
        begin
            result_next.ir_level   = 1'b0;
            result_next.frame_done = 1'b0;
            if (item.command == CMD_SEND)
            begin
                if (!active_reg)
                begin
                    active_next = 1'b1;
                    seg_next    = SEG_LEAD_MARK;
                    slot_next   = MARK_INIT;
                    bits_next   = {item.address, item.address, item.key_code,
                                   ~item.key_code};
                    left_next   = FRAME_BITS_INIT;
                    phase_next  = 2'd0;
                end
            end
            else if (active_reg)
            begin
                unique case (seg_reg)
                    SEG_LEAD_MARK:
                    begin
                        result_next.ir_level = 1'b1;
                        if (slot_reg <= SLOT_W'(1))
                        begin
                            seg_next  = SEG_LEAD_SPACE;
                            slot_next = SPACE_INIT;
                        end
                        else
                        begin
                            slot_next = slot_reg - SLOT_W'(1);
                        end
                    end
                    SEG_LEAD_SPACE:
                    begin
                        if (slot_reg <= SLOT_W'(1))
                        begin
                            seg_next  = SEG_DATA;
                            slot_next = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg - SLOT_W'(1);
                        end
                    end
                    SEG_DATA:
                    begin
                        result_next.ir_level = (phase_reg == 2'd0);
                        if (phase_reg >= last_phase)
                        begin
                            phase_next = 2'd0;
                            bits_next  = {bits_reg[FRAME_BITS-2:0], 1'b0};
                            left_next  = left_dec;
                            if (left_dec == 6'd0)
                            begin
                                seg_next = SEG_STOP;
                            end
                        end
                        else
                        begin
                            phase_next = phase_reg + 2'd1;
                        end
                    end
                    SEG_STOP:
                    begin
                        result_next.ir_level = 1'b1;
                        seg_next             = SEG_END;
                    end
                    default:
                    begin
                        // end of frame, or a segment code that means nothing
                        active_next            = 1'b0;
                        seg_next               = SEG_IDLE;
                        slot_next              = '0;
                        bits_next              = '0;
                        left_next              = '0;
                        phase_next             = 2'd0;
                        result_next.frame_done = 1'b1;
                    end
                endcase
            end
            result_next.busy_res = active_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (process)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            seg_reg       <= SEG_IDLE;
            slot_reg      <= '0;
            left_reg      <= '0;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            seg_reg       <= seg_next;
            slot_reg      <= slot_next;
            left_reg      <= left_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        bits_reg   <= bits_next;
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// File: rtl/irpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_checker
// Port-level checks on the frame sender's results, bound to the top level.
// ----------------------------------------------------------------------------
module irpd_checker (
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_ready,
    input logic ir_level,
    input logic busy_res,
    input logic frame_done
);

    // A stalled result holds its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(ir_level)
            && $stable(busy_res) && $stable(frame_done))
        else $error("result changed while stalled");

    // The ending tick leaves the sender idle with the line low
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_done |-> !busy_res && !ir_level)
        else $error("frame_done with busy or mark");

    // A mark is only driven while a frame is in flight
    a_mark_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ir_level |-> busy_res)
        else $error("mark driven while idle");

    // No result is valid when reset is first seen released
    a_no_early: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid straight out of reset");

endmodule

bind ir_pulse_distance_frame_sender irpd_checker u_irpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .ir_level   (results.ir_level),
    .busy_res   (results.busy_res),
    .frame_done (results.frame_done)
);
